@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: size constants, operation and
// status codes, and the word types shared by the cells and the top level.
// Depends on nothing.
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Contents of one queue slot.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic [2:0] prio;
   } slot_type;

   // Command broadcast to every cell for the word being accepted.
   typedef struct packed {
      logic       insert;
      logic       remove;
      logic [7:0] data;
      logic [2:0] prio;
   } cell_cmd_type;

endpackage

@@ rtl/spq_if.sv @@
// Channel interfaces for the sorted priority queue: request and response,
// each with valid, ready and payload. Depends on spq_pkg.
interface spq_req_if;
   logic               valid;
   logic               ready;
   spq_pkg::op_type    op;
   logic [7:0]         item_data;
   logic [2:0]         item_priority;

   modport source (output valid, output op, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input op, input item_data, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [7:0]            head_data;
   logic [2:0]            head_priority;
   logic [7:0]            removed_data;
   logic [4:0]            entry_count;
   logic                  is_empty;
   spq_pkg::status_type   status;

   modport source (output valid, output head_data, output head_priority,
                   output removed_data, output entry_count, output is_empty,
                   output status, input ready);
   modport sink   (input valid, input head_data, input head_priority,
                   input removed_data, input entry_count, input is_empty,
                   input status, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted queue chain. It compares its priority with the new
// word and decides locally to hold, take the new word or shift. Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                  prev_keep,
   input  spq_pkg::slot_type     prev_slot,
   input  spq_pkg::slot_type     next_slot,
   output logic                  keep,
   output spq_pkg::slot_type     slot,
   output spq_pkg::slot_type     slot_in
);
   import spq_pkg::*;

   logic       valid_ff;
   logic [7:0] data_ff;
   logic [2:0] priority_ff;

   assign slot = '{valid: valid_ff, data: data_ff, prio: priority_ff};

   // Entries of greater or equal priority stay put, so ties leave in arrival order.
   assign keep = valid_ff && (priority_ff >= cmd.prio);

   always_comb begin
      slot_in = slot;
      if (cmd.remove) begin
         slot_in = next_slot;
      end else if (cmd.insert && !keep) begin
         if (prev_keep) begin
            slot_in = '{valid: 1'b1, data: cmd.data, prio: cmd.prio};
         end else begin
            slot_in = prev_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= slot_in.data;
      priority_ff <= slot_in.prio;
   end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue built as a chain of DEPTH spq_cell slots, head at slot 0.
// Depends on spq_pkg, spq_if and spq_cell.
//
// Usage:
//   The req channel carries one word per operation: op selects enqueue or
//   dequeue of the head; item_data and item_priority matter on enqueue only.
//   Every accepted word yields exactly one rsp word that describes the queue
//   after the operation: head data and priority (zero when empty), the byte
//   removed by a dequeue, the entry count, an empty flag and a status code.
//   An enqueue into a full queue is dropped with status full; a dequeue of an
//   empty queue changes nothing and reports status empty.
//   The response word is registered at the edge that accepts the request.
//   Every cell compares and shifts in that same cycle, so the block takes one
//   word per cycle while the response register is empty or being drained.
//   The response register doubles as the buffer between the two sides: req.ready
//   stays high while the register is empty or being drained this cycle, so a
//   stalled receiver holds back at most one word and the queue accepts
//   nothing more until it is taken.
//   Synchronous reset empties the queue and drops any pending response word.
module sorted_priority_queue (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   slot_type     slot    [DEPTH];
   slot_type     slot_in [DEPTH];
   logic [DEPTH-1:0] keep;
   cell_cmd_type cmd;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       head_data_ff, head_data_in;
   logic [2:0]       head_priority_ff, head_priority_in;
   logic [7:0]       removed_ff, removed_in;
   logic [4:0]       entry_count_ff, entry_count_in;
   logic             is_empty_ff, is_empty_in;
   status_type       status_ff, status_in;

   logic              accept, full, empty, enq_ok, deq_ok;
   logic [CNT_W+4:0]  count_wide;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign enq_ok    = accept && (req.op == OP_ENQUEUE) && !full;
   assign deq_ok    = accept && (req.op == OP_DEQUEUE) && !empty;

   assign cmd = '{insert: enq_ok, remove: deq_ok,
                  data: req.item_data, prio: req.item_priority};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     prev_keep;
      slot_type prev_slot, next_slot;

      if (i == 0) begin : g_first
         assign prev_keep = 1'b1;
         assign prev_slot = '0;
      end else begin : g_mid
         assign prev_keep = keep[i-1];
         assign prev_slot = slot[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_slot = '0;
      end else begin : g_body
         assign next_slot = slot[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_keep (prev_keep),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .keep      (keep[i]),
         .slot      (slot[i]),
         .slot_in   (slot_in[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
      count_wide = {5'd0, count_in};

      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      head_data_in     = head_data_ff;
      head_priority_in = head_priority_ff;
      removed_in       = removed_ff;
      entry_count_in   = entry_count_ff;
      is_empty_in      = is_empty_ff;
      status_in        = status_ff;

      if (accept) begin
         rsp_valid_in     = 1'b1;
         head_data_in     = slot_in[0].valid ? slot_in[0].data : 8'd0;
         head_priority_in = slot_in[0].valid ? slot_in[0].prio : 3'd0;
         removed_in       = deq_ok ? slot[0].data : 8'd0;
         entry_count_in   = count_wide[4:0];
         is_empty_in      = (count_in == '0);
         priority if (req.op == OP_ENQUEUE && full) begin
            status_in = STATUS_FULL;
         end else if (req.op == OP_DEQUEUE && empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff     <= head_data_in;
      head_priority_ff <= head_priority_in;
      removed_ff       <= removed_in;
      entry_count_ff   <= entry_count_in;
      is_empty_ff      <= is_empty_in;
      status_ff        <= status_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.head_data     = head_data_ff;
   assign rsp.head_priority = head_priority_ff;
   assign rsp.removed_data  = removed_ff;
   assign rsp.entry_count   = entry_count_ff;
   assign rsp.is_empty      = is_empty_ff;
   assign rsp.status        = status_ff;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks for sorted_priority_queue, attached by the bind below.
// Depends on spq_pkg and the top level.
module spq_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [7:0]          rsp_head_data,
   input  logic [2:0]          rsp_head_priority,
   input  logic [7:0]          rsp_removed_data,
   input  logic [4:0]          rsp_entry_count,
   input  logic                rsp_is_empty,
   input  spq_pkg::status_type rsp_status
);
   import spq_pkg::*;

   // A stalled response word holds its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_head_data, rsp_head_priority, rsp_removed_data,
                  rsp_entry_count, rsp_is_empty, rsp_status}))
      else $error("response word changed while stalled");

   // A pending response that is not drained blocks further requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while response word is stalled");

   // An empty queue reports a zero head.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_head_data == 8'd0 && rsp_head_priority == 3'd0)
      else $error("empty queue shows a nonzero head");

   // A failed operation never removes a byte, and its empty flag tracks the count.
   a_fail_no_remove: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_removed_data == 8'd0 &&
         (DEPTH >= 32 || rsp_is_empty == (rsp_entry_count == 5'd0)))
      else $error("inconsistent response word");

   // Nothing is pending right after reset.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_head_data     (rsp.head_data),
   .rsp_head_priority (rsp.head_priority),
   .rsp_removed_data  (rsp.removed_data),
   .rsp_entry_count   (rsp.entry_count),
   .rsp_is_empty      (rsp.is_empty),
   .rsp_status        (rsp.status)
);

@@ verif/tb_sorted_priority_queue.sv @@
// Testbench for sorted_priority_queue: a directed table followed by random enqueue and
// dequeue words, each response checked against its table row or an in-bench sorted-list model.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 1528;

   typedef struct packed {
      logic [7:0] head_data;
      logic [2:0] head_prio;
      logic [7:0] removed;
      logic [4:0] count;
      logic       empty;
      status_type status;
   } report_type;

   typedef struct packed {
      logic       fixed;
      op_type     op;
      logic [7:0] data;
      logic [2:0] prio;
      report_type want;
   } script_row_type;

   localparam report_type UNCHECKED = '0;

   // Rows with fixed set carry their expected response; the rest follow the model.
   localparam script_row_type OPENING_WORDS [22] = '{
      '{1'b1, OP_DEQUEUE, 8'h00, 3'd0, '{8'h00, 3'd0, 8'h00, 5'd0, 1'b1, STATUS_EMPTY}},
      '{1'b1, OP_ENQUEUE, 8'hFF, 3'd7, '{8'hFF, 3'd7, 8'h00, 5'd1, 1'b0, STATUS_OK}},
      '{1'b1, OP_ENQUEUE, 8'h00, 3'd0, '{8'hFF, 3'd7, 8'h00, 5'd2, 1'b0, STATUS_OK}},
      '{1'b0, OP_ENQUEUE, 8'h33, 3'd7, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h11, 3'd3, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h22, 3'd3, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h55, 3'd0, UNCHECKED},
      '{1'b0, OP_DEQUEUE, 8'hA5, 3'd5, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'hAA, 3'd5, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h01, 3'd1, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h5A, 3'd6, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'hC3, 3'd2, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h3C, 3'd4, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h80, 3'd3, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h7F, 3'd6, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h0F, 3'd0, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'hF0, 3'd5, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h99, 3'd1, UNCHECKED},
      '{1'b0, OP_ENQUEUE, 8'h66, 3'd4, UNCHECKED},
      '{1'b1, OP_ENQUEUE, 8'h44, 3'd7, '{8'h33, 3'd7, 8'h00, 5'd16, 1'b0, STATUS_FULL}},
      '{1'b0, OP_DEQUEUE, 8'h00, 3'd0, UNCHECKED},
      '{1'b0, OP_DEQUEUE, 8'hFF, 3'd7, UNCHECKED}
   };

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Model of the queue contents, head at index 0.
   logic [7:0] held_data [DEPTH];
   logic [2:0] held_prio [DEPTH];
   int         held;

   report_type pending_reports [$];
   int         mismatches;
   int         burst_left;
   int         stall_mode;
   int         mode_left;
   int         cycle_count;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic report_type next_queue_report(op_type op, logic [7:0] d,
                                                    logic [2:0] p);
      report_type r;
      int         slot;
      r = '0;
      r.status = STATUS_OK;
      if (op == OP_ENQUEUE) begin
         if (held >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // Equal priorities stay in arrival order, so skip past them.
            slot = 0;
            while (slot < held && held_prio[slot] >= p) slot++;
            for (int i = held; i > slot; i--) begin
               held_data[i] = held_data[i - 1];
               held_prio[i] = held_prio[i - 1];
            end
            held_data[slot] = d;
            held_prio[slot] = p;
            held++;
         end
      end else if (held == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.removed = held_data[0];
         for (int i = 0; i + 1 < held; i++) begin
            held_data[i] = held_data[i + 1];
            held_prio[i] = held_prio[i + 1];
         end
         held--;
      end
      if (held > 0) begin
         r.head_data = held_data[0];
         r.head_prio = held_prio[0];
      end
      r.count = 5'(held);
      r.empty = (held == 0);
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Entered at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_word(op_type op, logic [7:0] d, logic [2:0] p, logic fixed,
                             report_type want);
      report_type predicted;
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.item_data     <= d;
      req_ch.item_priority <= p;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = next_queue_report(op, d, p);
      pending_reports.push_back(fixed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   always @(negedge clock) begin : ready_pattern
      cycle_count++;
      if (mode_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(10, 100);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (cycle_count % 5 != 0);
      endcase
   end

   always @(posedge clock) begin : response_check
      report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            flag_mismatch("unexpected word, head_data", rsp_ch.head_data, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_ch.head_data !== want.head_data)
               flag_mismatch("head_data", rsp_ch.head_data, want.head_data);
            if (rsp_ch.head_priority !== want.head_prio)
               flag_mismatch("head_priority", rsp_ch.head_priority, want.head_prio);
            if (rsp_ch.removed_data !== want.removed)
               flag_mismatch("removed_data", rsp_ch.removed_data, want.removed);
            if (rsp_ch.entry_count !== want.count)
               flag_mismatch("entry_count", rsp_ch.entry_count, want.count);
            if (rsp_ch.is_empty !== want.empty)
               flag_mismatch("is_empty", rsp_ch.is_empty, want.empty);
            if (rsp_ch.status !== want.status)
               flag_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end while (quiet < STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int     phase_left;
      int     enqueue_pct;
      op_type op;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_ENQUEUE;
      req_ch.item_data     = '0;
      req_ch.item_priority = '0;
      rsp_ch.ready         = 1'b0;
      held        = 0;
      mismatches  = 0;
      burst_left  = 1;
      stall_mode  = 0;
      mode_left   = 0;
      cycle_count = 0;
      phase_left  = 0;
      enqueue_pct = 50;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_WORDS[i]) begin
         offer_word(OPENING_WORDS[i].op, OPENING_WORDS[i].data, OPENING_WORDS[i].prio,
                    OPENING_WORDS[i].fixed, OPENING_WORDS[i].want);
         pace_sender();
      end

      // Alternate filling, draining and balanced phases so the queue keeps
      // passing through full and empty.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (phase_left <= 0) begin
            phase_left = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
               0: enqueue_pct = 80;
               1: enqueue_pct = 20;
               default: enqueue_pct = 50;
            endcase
         end
         phase_left--;
         op = ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         offer_word(op, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0,
                    UNCHECKED);
         pace_sender();
      end
      req_ch.valid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
verif/tb_sorted_priority_queue.sv
